@@ hw/rtl/selective_repeat_receive_window_core_assert.svh @@
// assertion macros shared by the receive window checks
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, quiet during reset
`define SRRW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, quiet during reset
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/srrw_pkg.sv @@
// shared types and constants of the selective repeat receive window
package srrw_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int SEQ_W         = 31;
    localparam int TS_W          = 32;
    localparam int CMD_W         = 2;
    localparam int KIND_W        = 2;
    localparam int WIN_W         = 5;

    localparam logic [SEQ_W-1:0] SEQ_MAX      = {SEQ_W{1'b1}};
    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROBE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] tag;
        logic             fin;
    } t_slot;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [SEQ_W-1:0] key;
        logic             fin;
    } t_cell_ctl;

endpackage

@@ hw/rtl/selective_repeat_receive_window_core.sv @@
// selective repeat receive window: top level with sorted cell chain and sequencer
//
// channel   direction  handshake                      payload
// command   in         start high while busy low      i_cmd i_seq_num i_time_stamp i_final_flag
// result    out        o_strobe, one cycle, no stall  o_kind o_ack_seq o_echo_ts o_free_window
//                                                     o_delivered_seq o_delivered_final o_run_end
// config    in         i_cfg_valid and o_cfg_ready    i_window_size
//
// probe: reply in the cycle after the start, busy stays low
// data packet: lookup, then insert, then an advance step for each held successor the cumulative count
//   walks over (at most depth) and a last one that gives the ack; one chain compare per cycle sets the pace
// drain: deliverable words come out back to back while the chain shifts; with none it goes idle silently
// reset clears slot valid bits and counts and sets the window register to 16; results never stall
module selective_repeat_receive_window_core #(
    parameter int WINDOW_DEPTH = srrw_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [srrw_pkg::CMD_W-1:0]  i_cmd,
    input  logic [srrw_pkg::SEQ_W-1:0]  i_seq_num,
    input  logic [srrw_pkg::TS_W-1:0]   i_time_stamp,
    input  logic                        i_final_flag,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [srrw_pkg::WIN_W-1:0]  i_window_size,
    output logic                        o_strobe,
    output logic [srrw_pkg::KIND_W-1:0] o_kind,
    output logic [srrw_pkg::SEQ_W-1:0]  o_ack_seq,
    output logic [srrw_pkg::TS_W-1:0]   o_echo_ts,
    output logic [srrw_pkg::WIN_W-1:0]  o_free_window,
    output logic [srrw_pkg::SEQ_W-1:0]  o_delivered_seq,
    output logic                        o_delivered_final,
    output logic                        o_run_end
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CW    = (CNT_W > srrw_pkg::WIN_W) ? CNT_W : srrw_pkg::WIN_W;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LOOKUP  = 5'b00010,
        ST_INSERT  = 5'b00100,
        ST_ADVANCE = 5'b01000,
        ST_DRAIN   = 5'b10000
    } t_state;

    // control state
    t_state                       r_state, n_state;
    logic [srrw_pkg::SEQ_W-1:0]   r_cum, n_cum;
    logic [CNT_W-1:0]             r_held, n_held;
    logic                         r_done, n_done;
    logic [srrw_pkg::WIN_W-1:0]   r_window, n_window;
    logic                         r_strobe, n_strobe;

    // payload state
    logic [srrw_pkg::SEQ_W-1:0]   r_seq, n_seq;
    logic [srrw_pkg::TS_W-1:0]    r_ts, n_ts;
    logic                         r_fin, n_fin;
    logic                         r_dup, n_dup;
    logic [srrw_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [srrw_pkg::SEQ_W-1:0]   r_ack_seq, n_ack_seq;
    logic [srrw_pkg::TS_W-1:0]    r_echo_ts, n_echo_ts;
    logic [srrw_pkg::WIN_W-1:0]   r_free, n_free;
    logic [srrw_pkg::SEQ_W-1:0]   r_dseq, n_dseq;
    logic                         r_dfin, n_dfin;
    logic                         r_run_end, n_run_end;

    // chain wiring
    srrw_pkg::t_cell_ctl          w_ctl;
    srrw_pkg::t_slot              w_slot [0:WINDOW_DEPTH];
    srrw_pkg::t_slot              w_left [0:WINDOW_DEPTH-1];
    logic [WINDOW_DEPTH-1:0]      w_left_lt;
    logic [WINDOW_DEPTH-1:0]      w_lt;
    logic [WINDOW_DEPTH-1:0]      w_eq;

    logic [CW-1:0]                w_eff;
    logic [CW-1:0]                w_held_ext;
    logic [srrw_pkg::WIN_W-1:0]   w_free;
    logic                         w_room;
    logic                         w_store;
    logic                         w_in_order;
    logic                         w_hit;
    logic                         w_del0;
    logic                         w_del1;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_slot[WINDOW_DEPTH] = '0;

    for (genvar gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_left[gi]    = '0;
            assign w_left_lt[gi] = 1'b1;
        end else begin : g_body
            assign w_left[gi]    = w_slot[gi-1];
            assign w_left_lt[gi] = w_lt[gi-1];
        end

        srrw_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_left    (w_left[gi]),
            .i_left_lt (w_left_lt[gi]),
            .i_right   (w_slot[gi+1]),
            .o_slot    (w_slot[gi]),
            .o_lt      (w_lt[gi]),
            .o_eq      (w_eq[gi])
        );
    end

    // effective window is the register clamped to the chain depth
    always_comb begin
        w_eff = (CW'(r_window) > CW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : CW'(r_window);
        w_held_ext = CW'(r_held);
        w_free = (w_held_ext >= w_eff) ? '0 : srrw_pkg::WIN_W'(w_eff - w_held_ext);
        w_room = (w_held_ext < w_eff);
    end

    assign w_store    = (r_state == ST_INSERT) && !r_dup && w_room && (r_seq > r_cum);
    assign w_in_order = ({1'b0, r_seq} == ({1'b0, r_cum} + 32'd1));
    assign w_hit      = (|w_eq) && (r_cum != srrw_pkg::SEQ_MAX);
    // chain is sorted, so the head is the smallest tag and its neighbour the next
    assign w_del0     = w_slot[0].valid && (w_slot[0].tag <= r_cum);
    assign w_del1     = w_slot[1].valid && (w_slot[1].tag <= r_cum);

    always_comb begin
        w_ctl.key = (r_state == ST_ADVANCE) ? (r_cum + 1'b1) : r_seq;
        w_ctl.fin = r_fin;
        if (w_store) begin
            w_ctl.op = srrw_pkg::CELL_INSERT;
        end else if ((r_state == ST_DRAIN) && w_del0) begin
            w_ctl.op = srrw_pkg::CELL_SHIFT;
        end else begin
            w_ctl.op = srrw_pkg::CELL_HOLD;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cum     = r_cum;
        n_held    = r_held;
        n_done    = r_done;
        n_window  = r_window;
        n_strobe  = 1'b0;
        n_seq     = r_seq;
        n_ts      = r_ts;
        n_fin     = r_fin;
        n_dup     = r_dup;
        n_kind    = r_kind;
        n_ack_seq = r_ack_seq;
        n_echo_ts = r_echo_ts;
        n_free    = r_free;
        n_dseq    = r_dseq;
        n_dfin    = r_dfin;
        n_run_end = r_run_end;

        if (i_cfg_valid) begin
            n_window = i_window_size;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    priority if (i_cmd == srrw_pkg::CMD_DATA) begin
                        n_seq   = i_seq_num;
                        n_ts    = i_time_stamp;
                        n_fin   = i_final_flag;
                        n_state = ST_LOOKUP;
                    end else if (i_cmd == srrw_pkg::CMD_PROBE) begin
                        n_strobe  = 1'b1;
                        n_kind    = srrw_pkg::KIND_PROBE;
                        n_ack_seq = '0;
                        n_echo_ts = '0;
                        n_free    = w_free;
                        n_dseq    = '0;
                        n_dfin    = 1'b0;
                        n_run_end = 1'b1;
                    end else if (i_cmd == srrw_pkg::CMD_DRAIN) begin
                        if (!r_done) begin
                            n_state = ST_DRAIN;
                        end
                    end else begin
                    end
                end
            end
            ST_LOOKUP: begin
                n_dup   = |w_eq;
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                if (w_store) begin
                    n_held = r_held + 1'b1;
                end
                // in-order arrival moves the count even when the packet was not kept
                if (w_in_order) begin
                    n_cum = r_cum + 1'b1;
                end
                n_state = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                if (w_hit) begin
                    n_cum = r_cum + 1'b1;
                end else begin
                    n_strobe  = 1'b1;
                    n_kind    = srrw_pkg::KIND_ACK;
                    n_ack_seq = r_cum;
                    n_echo_ts = r_ts;
                    n_free    = w_free;
                    n_dseq    = '0;
                    n_dfin    = 1'b0;
                    n_run_end = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (w_del0) begin
                    n_strobe  = 1'b1;
                    n_kind    = srrw_pkg::KIND_DELIVER;
                    n_ack_seq = '0;
                    n_echo_ts = '0;
                    n_free    = '0;
                    n_dseq    = w_slot[0].tag;
                    n_dfin    = w_slot[0].fin;
                    n_run_end = w_slot[0].fin || !w_del1;
                    if (r_held != '0) begin
                        n_held = r_held - 1'b1;
                    end
                    if (w_slot[0].fin) begin
                        n_done = 1'b1;
                    end
                    if (w_slot[0].fin || !w_del1) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cum    <= '0;
            r_held   <= '0;
            r_done   <= 1'b0;
            r_window <= srrw_pkg::WINDOW_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cum    <= n_cum;
            r_held   <= n_held;
            r_done   <= n_done;
            r_window <= n_window;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_ts      <= n_ts;
        r_fin     <= n_fin;
        r_dup     <= n_dup;
        r_kind    <= n_kind;
        r_ack_seq <= n_ack_seq;
        r_echo_ts <= n_echo_ts;
        r_free    <= n_free;
        r_dseq    <= n_dseq;
        r_dfin    <= n_dfin;
        r_run_end <= n_run_end;
    end

    assign o_strobe          = r_strobe;
    assign o_kind            = r_kind;
    assign o_ack_seq         = r_ack_seq;
    assign o_echo_ts         = r_echo_ts;
    assign o_free_window     = r_free;
    assign o_delivered_seq   = r_dseq;
    assign o_delivered_final = r_dfin;
    assign o_run_end         = r_run_end;

endmodule

@@ hw/rtl/srrw_cell.sv @@
// one slot of the sorted holding chain
module srrw_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srrw_pkg::t_cell_ctl i_ctl,
    input  srrw_pkg::t_slot   i_left,
    input  logic              i_left_lt,
    input  srrw_pkg::t_slot   i_right,
    output srrw_pkg::t_slot   o_slot,
    output logic              o_lt,
    output logic              o_eq
);

    logic                       r_valid;
    logic [srrw_pkg::SEQ_W-1:0] r_tag;
    logic                       r_fin;
    logic                       n_valid;
    logic [srrw_pkg::SEQ_W-1:0] n_tag;
    logic                       n_fin;

    assign o_slot = '{valid: r_valid, tag: r_tag, fin: r_fin};
    assign o_lt   = r_valid && (r_tag < i_ctl.key);
    assign o_eq   = r_valid && (r_tag == i_ctl.key);

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_fin   = r_fin;
        unique case (i_ctl.op)
            srrw_pkg::CELL_HOLD: begin
            end
            srrw_pkg::CELL_INSERT: begin
                // smaller tags stay, the gap opens where the left one is smaller
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_valid = 1'b1;
                        n_tag   = i_ctl.key;
                        n_fin   = i_ctl.fin;
                    end else begin
                        n_valid = i_left.valid;
                        n_tag   = i_left.tag;
                        n_fin   = i_left.fin;
                    end
                end
            end
            srrw_pkg::CELL_SHIFT: begin
                n_valid = i_right.valid;
                n_tag   = i_right.tag;
                n_fin   = i_right.fin;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_fin <= n_fin;
    end

endmodule

@@ hw/rtl/srrw_checker.sv @@
// port-level checks of the receive window, bound to the top level
`include "selective_repeat_receive_window_core_assert.svh"

module srrw_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [srrw_pkg::CMD_W-1:0]  i_cmd,
    input logic                        o_strobe,
    input logic [srrw_pkg::KIND_W-1:0] o_kind,
    input logic                        o_delivered_final,
    input logic                        o_run_end
);

    logic w_accept;
    assign w_accept = start && !busy;

    // a probe is answered on the very next cycle with a single word
    `SRRW_ASSERT_NEXT(a_probe_reply, w_accept && (i_cmd == srrw_pkg::CMD_PROBE), o_strobe && (o_kind == srrw_pkg::KIND_PROBE) && o_run_end, "probe not answered in the next cycle")

    // a data packet occupies the sequencer and gives no word straight away
    `SRRW_ASSERT_NEXT(a_data_busy, w_accept && (i_cmd == srrw_pkg::CMD_DATA), busy && !o_strobe, "data packet did not hold the block busy")

    // an ack only comes out of a busy data sequence and closes it
    `SRRW_ASSERT_NOW(a_ack_after_busy, o_strobe && (o_kind == srrw_pkg::KIND_ACK), $past(busy) && o_run_end, "ack without a preceding data sequence")

    // more words of the same run still to come means the drain is still going
    `SRRW_ASSERT_NOW(a_run_continues, o_strobe && !o_run_end, busy && (o_kind == srrw_pkg::KIND_DELIVER) && !o_delivered_final, "open run while idle or after final word")

endmodule

bind selective_repeat_receive_window_core srrw_checker u_srrw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_cmd             (i_cmd),
    .o_strobe          (o_strobe),
    .o_kind            (o_kind),
    .o_delivered_final (o_delivered_final),
    .o_run_end         (o_run_end)
);
